// File: sv/chacha_pkg.sv
// Shared types, constants and functions for the ChaCha stream cipher block.
`timescale 1ns / 1ps

package chacha_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int WORDS       = BLOCK_BYTES / 4;
  localparam int WORD_IDX_W  = $clog2(WORDS);
  localparam int POS_W       = $clog2(BLOCK_BYTES) + 1;
  localparam int CFG_IDX_W   = 8;

  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_01   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_23   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_45   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_67   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTR_N0   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_12 = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_128  = 8'd7;

  localparam logic [1:0] ROUNDS_8  = 2'd0;
  localparam logic [1:0] ROUNDS_12 = 2'd1;
  localparam logic [1:0] ROUNDS_20 = 2'd2;

  localparam logic [3:0] DOUBLES_8  = 4'd4;
  localparam logic [3:0] DOUBLES_12 = 4'd6;
  localparam logic [3:0] DOUBLES_20 = 4'd10;

  // One row of the quarter round: which add, which xor target and rotation.
  localparam logic [1:0] LINE_A_D16 = 2'd0;
  localparam logic [1:0] LINE_C_B12 = 2'd1;
  localparam logic [1:0] LINE_A_D8  = 2'd2;
  localparam logic [1:0] LINE_C_B7  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } chacha_state_t;

  typedef struct packed {
    logic       accept_fast;
    logic       accept_slow;
    logic       load;
    logic       round;
    logic [1:0] line;
    logic       diag;
    logic       feed;
    logic       emit;
  } chacha_cmd_t;

  typedef struct packed {
    logic       need_block;
    logic       out_stall;
    logic [3:0] doubles;
  } chacha_status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

// File: sv/chacha_ctrl.sv
// Controller state machine that sequences request handling and block generation.
`timescale 1ns / 1ps

module chacha_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  chacha_pkg::chacha_status_t status,
  output chacha_pkg::chacha_cmd_t    cmd
);

  chacha_pkg::chacha_state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [3:0] dbl_r, dbl_nxt;
  logic       last_step;

  assign last_step = (step_r == 3'd7) && (dbl_r == status.doubles - 4'd1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chacha_pkg::ST_IDLE: begin
        if (in_valid && !status.out_stall && status.need_block) state_nxt = chacha_pkg::ST_LOAD;
      end
      chacha_pkg::ST_LOAD:  state_nxt = chacha_pkg::ST_ROUND;
      chacha_pkg::ST_ROUND: begin
        if (last_step) state_nxt = chacha_pkg::ST_FEED;
      end
      chacha_pkg::ST_FEED:  state_nxt = chacha_pkg::ST_EMIT;
      chacha_pkg::ST_EMIT: begin
        if (!status.out_stall) state_nxt = chacha_pkg::ST_IDLE;
      end
      default: state_nxt = chacha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.line        = step_r[1:0];
    cmd.diag        = step_r[2];
    step_nxt        = step_r;
    dbl_nxt         = dbl_r;
    case (state_r)
      chacha_pkg::ST_IDLE: begin
        in_ready        = !status.out_stall;
        cmd.accept_fast = in_valid && in_ready && !status.need_block;
        cmd.accept_slow = in_valid && in_ready && status.need_block;
      end
      chacha_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        step_nxt = '0;
        dbl_nxt  = '0;
      end
      chacha_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        step_nxt  = step_r + 3'd1;
        if (step_r == 3'd7) dbl_nxt = dbl_r + 4'd1;
      end
      chacha_pkg::ST_FEED: cmd.feed = 1'b1;
      chacha_pkg::ST_EMIT: cmd.emit = !status.out_stall;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chacha_pkg::ST_IDLE;
      step_r  <= '0;
      dbl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dbl_r   <= dbl_nxt;
    end
  end

endmodule

// File: sv/chacha_dp.sv
// Datapath: configuration registers, cipher state, quarter-round rows and output register.
`timescale 1ns / 1ps

module chacha_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                          cfg_data,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_restart,
  input  logic                                 in_end_of_call,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 out_end_of_call,
  input  chacha_pkg::chacha_cmd_t              cmd,
  output chacha_pkg::chacha_status_t           status
);

  logic [63:0] key01_r, key23_r, key45_r, key67_r, ctr_n0_r, nonce12_r;
  logic [1:0]  mode_r;
  logic        key128_r;

  logic [31:0] counter_r, counter_nxt;
  logic [31:0] nonce0_r, nonce0_nxt;
  logic [chacha_pkg::POS_W-1:0] pos_r, pos_nxt;

  logic [31:0] w_r [chacha_pkg::WORDS];
  logic [31:0] w_nxt [chacha_pkg::WORDS];
  logic [31:0] init_w [chacha_pkg::WORDS];
  logic [31:0] round_w [chacha_pkg::WORDS];

  logic [7:0]  hold_data_r, hold_data_nxt;
  logic        hold_eoc_r, hold_eoc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_eoc_r, out_eoc_nxt;

  logic [31:0] ks_word, ks_shift;
  logic [63:0] key_hi0, key_hi1;

  logic [3:0]  doubles;
  logic        need_block;
  logic        out_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r   <= '0;
      key23_r   <= '0;
      key45_r   <= '0;
      key67_r   <= '0;
      ctr_n0_r  <= '0;
      nonce12_r <= '0;
      mode_r    <= chacha_pkg::ROUNDS_20;
      key128_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        chacha_pkg::CFG_KEY_01:   key01_r   <= cfg_data;
        chacha_pkg::CFG_KEY_23:   key23_r   <= cfg_data;
        chacha_pkg::CFG_KEY_45:   key45_r   <= cfg_data;
        chacha_pkg::CFG_KEY_67:   key67_r   <= cfg_data;
        chacha_pkg::CFG_CTR_N0:   ctr_n0_r  <= cfg_data;
        chacha_pkg::CFG_NONCE_12: nonce12_r <= cfg_data;
        chacha_pkg::CFG_ROUNDS:   mode_r    <= cfg_data[1:0];
        chacha_pkg::CFG_KEY_128:  key128_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mode_r)
      chacha_pkg::ROUNDS_8:  doubles = chacha_pkg::DOUBLES_8;
      chacha_pkg::ROUNDS_12: doubles = chacha_pkg::DOUBLES_12;
      default:               doubles = chacha_pkg::DOUBLES_20;
    endcase
  end

  assign need_block = in_restart || (pos_r == '0) ||
                      (pos_r >= chacha_pkg::POS_W'(chacha_pkg::BLOCK_BYTES));
  assign out_stall  = out_valid_r && !out_ready;
  assign status     = {need_block, out_stall, doubles};

  assign key_hi0 = key128_r ? key01_r : key45_r;
  assign key_hi1 = key128_r ? key23_r : key67_r;

  always_comb begin
    for (int i = 0; i < 4; i++) init_w[i] = chacha_pkg::SIGMA[i];
    init_w[4]  = key01_r[31:0];
    init_w[5]  = key01_r[63:32];
    init_w[6]  = key23_r[31:0];
    init_w[7]  = key23_r[63:32];
    init_w[8]  = key_hi0[31:0];
    init_w[9]  = key_hi0[63:32];
    init_w[10] = key_hi1[31:0];
    init_w[11] = key_hi1[63:32];
    init_w[12] = counter_r;
    init_w[13] = nonce0_r;
    init_w[14] = nonce12_r[31:0];
    init_w[15] = nonce12_r[63:32];
  end

  // Four quarter rounds run side by side, one row of each per cycle.
  always_comb begin : round_unit
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] sum;
    for (int i = 0; i < chacha_pkg::WORDS; i++) round_w[i] = w_r[i];
    for (int i = 0; i < 4; i++) begin
      ia  = {2'b00, 2'(i)};
      ib  = {2'b01, 2'(i) + {1'b0, cmd.diag}};
      ic  = {2'b10, 2'(i) + {cmd.diag, 1'b0}};
      id  = {2'b11, 2'(i) + {cmd.diag, cmd.diag}};
      sum = '0;
      case (cmd.line)
        chacha_pkg::LINE_A_D16: begin
          sum         = w_r[ia] + w_r[ib];
          round_w[ia] = sum;
          round_w[id] = chacha_pkg::rotl32(w_r[id] ^ sum, 16);
        end
        chacha_pkg::LINE_C_B12: begin
          sum         = w_r[ic] + w_r[id];
          round_w[ic] = sum;
          round_w[ib] = chacha_pkg::rotl32(w_r[ib] ^ sum, 12);
        end
        chacha_pkg::LINE_A_D8: begin
          sum         = w_r[ia] + w_r[ib];
          round_w[ia] = sum;
          round_w[id] = chacha_pkg::rotl32(w_r[id] ^ sum, 8);
        end
        chacha_pkg::LINE_C_B7: begin
          sum         = w_r[ic] + w_r[id];
          round_w[ic] = sum;
          round_w[ib] = chacha_pkg::rotl32(w_r[ib] ^ sum, 7);
        end
        default: sum = '0;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < chacha_pkg::WORDS; i++) begin
      if (cmd.load)       w_nxt[i] = init_w[i];
      else if (cmd.round) w_nxt[i] = round_w[i];
      else if (cmd.feed)  w_nxt[i] = w_r[i] + init_w[i];
      else                w_nxt[i] = w_r[i];
    end
  end

  assign ks_word  = w_r[pos_r[chacha_pkg::WORD_IDX_W+1:2]];
  assign ks_shift = ks_word >> {pos_r[1:0], 3'b000};

  always_comb begin
    counter_nxt   = counter_r;
    nonce0_nxt    = nonce0_r;
    pos_nxt       = pos_r;
    hold_data_nxt = hold_data_r;
    hold_eoc_nxt  = hold_eoc_r;
    out_byte_nxt  = out_byte_r;
    out_eoc_nxt   = out_eoc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.accept_slow) begin
      hold_data_nxt = in_data_byte;
      hold_eoc_nxt  = in_end_of_call;
      if (in_restart) begin
        counter_nxt = ctr_n0_r[31:0];
        nonce0_nxt  = ctr_n0_r[63:32];
      end
    end
    if (cmd.feed) begin
      counter_nxt = counter_r + 32'd1;
      if (counter_r == '1) nonce0_nxt = nonce0_r + 32'd1;
    end
    if (cmd.accept_fast) begin
      out_byte_nxt  = in_data_byte ^ ks_shift[7:0];
      out_eoc_nxt   = in_end_of_call;
      out_valid_nxt = 1'b1;
      pos_nxt       = pos_r + chacha_pkg::POS_W'(1);
    end
    if (cmd.emit) begin
      out_byte_nxt  = hold_data_r ^ w_r[0][7:0];
      out_eoc_nxt   = hold_eoc_r;
      out_valid_nxt = 1'b1;
      pos_nxt       = chacha_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r   <= '0;
      nonce0_r    <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      counter_r   <= counter_nxt;
      nonce0_r    <= nonce0_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < chacha_pkg::WORDS; i++) w_r[i] <= w_nxt[i];
    hold_data_r <= hold_data_nxt;
    hold_eoc_r  <= hold_eoc_nxt;
    out_byte_r  <= out_byte_nxt;
    out_eoc_r   <= out_eoc_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_end_of_call = out_eoc_r;

endmodule

// File: sv/chacha_stream_cipher.sv
// Top level of the ChaCha keystream XOR block: controller, datapath and checks.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | input     | in_valid / in_ready   | in_data_byte, in_restart, in_end_of_call
//   out_    | output    | out_valid / out_ready | out_byte, out_end_of_call
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request within the current keystream block is registered in the next cycle.
// A request that starts a new block has its result registered after the states load,
// round (D = 4, 6 or 10 double rounds, shared quarter-round row unit), feed and emit.
// Reset is synchronous and active low; the keystream words are not reset.
// A stalled output holds its byte and blocks new requests until it is taken.
`timescale 1ns / 1ps

module chacha_stream_cipher (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [chacha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_restart,
  input  logic                             in_end_of_call,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_end_of_call
);

  chacha_pkg::chacha_cmd_t    cmd;
  chacha_pkg::chacha_status_t status;

  chacha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  chacha_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_data_byte    (in_data_byte),
    .in_restart      (in_restart),
    .in_end_of_call  (in_end_of_call),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_end_of_call (out_end_of_call),
    .cmd             (cmd),
    .status          (status)
  );

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept_fast, cmd.accept_slow, cmd.load, cmd.round, cmd.feed, cmd.emit}))
    else $error("More than one datapath command in a cycle.");

  a_load_then_round: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.round)
    else $error("Block generation did not start rounds after loading.");

  a_restart_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart |=> !in_ready)
    else $error("A restart request did not start block generation.");

  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_fast |=> out_valid)
    else $error("A request within the block produced no result.");

endmodule

// File: dv/chacha_stream_cipher_test.sv
// Self-checking testbench for the ChaCha keystream XOR block with its own keystream predictor.
`timescale 1ns / 1ps

module chacha_stream_cipher_test;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 850;
  localparam int MAX_IDLE = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [1:0] ROUNDS_RESERVED = 2'd3;
  localparam logic [chacha_pkg::CFG_IDX_W-1:0] CFG_INDEX_PAST_END = 8'd8;
  localparam logic [chacha_pkg::CFG_IDX_W-1:0] CFG_INDEX_TOP = 8'hFF;

  typedef struct packed {
    logic [7:0] text;
    logic       end_mark;
  } cipher_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [chacha_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]                      cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       in_data_byte = '0;
  logic                             in_restart = 1'b0;
  logic                             in_end_of_call = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [7:0]                       out_byte;
  logic                             out_end_of_call;

  chacha_stream_cipher dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_restart     (in_restart),
    .in_end_of_call (in_end_of_call),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_end_of_call(out_end_of_call)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies and keystream state of the predictor.
  logic [63:0]    key_reg [4];
  logic [63:0]    ctr_nonce0_reg;
  logic [63:0]    nonce12_reg;
  logic [1:0]     rounds_reg;
  logic           key128_reg;
  logic [31:0]    block_ctr;
  logic [31:0]    nonce_zero;
  logic [31:0]    ks_words [16];
  logic [31:0]    mix [16];
  logic [chacha_pkg::POS_W-1:0] ks_pos;

  cipher_result_t pending_results [$];
  int             error_count = 0;
  int             items_sent = 0;
  int             idle_count = 0;
  int             hold_off_request = 0;
  bit             idle_enabled = 1'b1;

  initial begin
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    ctr_nonce0_reg = '0;
    nonce12_reg = '0;
    rounds_reg = chacha_pkg::ROUNDS_20;
    key128_reg = 1'b0;
    block_ctr = '0;
    nonce_zero = '0;
    for (int i = 0; i < 16; i++) ks_words[i] = '0;
    ks_pos = '0;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x} << n;
    return twice[63:32];
  endfunction

  function automatic void mix_quarter(input int a, input int b, input int c, input int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rot_left(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rot_left(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rot_left(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rot_left(mix[b] ^ mix[c], 7);
  endfunction

  function automatic void build_keystream_block();
    logic [31:0] start [16];
    logic [63:0] upper;
    int          doubles;
    for (int i = 0; i < 4; i++) start[i] = chacha_pkg::SIGMA[i];
    for (int i = 0; i < 2; i++) begin
      start[4 + 2 * i] = key_reg[i][31:0];
      start[5 + 2 * i] = key_reg[i][63:32];
      upper = key128_reg ? key_reg[i] : key_reg[2 + i];
      start[8 + 2 * i] = upper[31:0];
      start[9 + 2 * i] = upper[63:32];
    end
    start[12] = block_ctr;
    start[13] = nonce_zero;
    start[14] = nonce12_reg[31:0];
    start[15] = nonce12_reg[63:32];
    case (rounds_reg)
      chacha_pkg::ROUNDS_8:  doubles = int'(chacha_pkg::DOUBLES_8);
      chacha_pkg::ROUNDS_12: doubles = int'(chacha_pkg::DOUBLES_12);
      default:               doubles = int'(chacha_pkg::DOUBLES_20);
    endcase
    for (int i = 0; i < 16; i++) mix[i] = start[i];
    for (int r = 0; r < doubles; r++) begin
      mix_quarter(0, 4, 8, 12);
      mix_quarter(1, 5, 9, 13);
      mix_quarter(2, 6, 10, 14);
      mix_quarter(3, 7, 11, 15);
      mix_quarter(0, 5, 10, 15);
      mix_quarter(1, 6, 11, 12);
      mix_quarter(2, 7, 8, 13);
      mix_quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + start[i];
  endfunction

  function automatic logic [7:0] next_keystream_byte(input logic restart);
    logic [31:0] word;
    if (restart) begin
      block_ctr = ctr_nonce0_reg[31:0];
      nonce_zero = ctr_nonce0_reg[63:32];
      ks_pos = '0;
    end
    if (ks_pos == 0 || ks_pos >= chacha_pkg::BLOCK_BYTES) begin
      build_keystream_block();
      block_ctr = block_ctr + 32'd1;
      if (block_ctr == 32'd0) nonce_zero = nonce_zero + 32'd1;
      ks_pos = '0;
    end
    word = ks_words[ks_pos[5:2]] >> (8 * ks_pos[1:0]);
    ks_pos = ks_pos + 1'b1;
    return word[7:0];
  endfunction

  function automatic void apply_register(input logic [chacha_pkg::CFG_IDX_W-1:0] index,
                                         input logic [63:0] data);
    case (index)
      chacha_pkg::CFG_KEY_01:   key_reg[0] = data;
      chacha_pkg::CFG_KEY_23:   key_reg[1] = data;
      chacha_pkg::CFG_KEY_45:   key_reg[2] = data;
      chacha_pkg::CFG_KEY_67:   key_reg[3] = data;
      chacha_pkg::CFG_CTR_N0:   ctr_nonce0_reg = data;
      chacha_pkg::CFG_NONCE_12: nonce12_reg = data;
      chacha_pkg::CFG_ROUNDS:   rounds_reg = data[1:0];
      chacha_pkg::CFG_KEY_128:  key128_reg = data[0];
      default: begin
      end
    endcase
  endfunction

  function automatic int draw_idle();
    return idle_enabled ? int'($urandom_range(0, MAX_IDLE)) : 0;
  endfunction

  function automatic logic [63:0] pick_word64();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic restart, input logic end_mark);
    int             gap;
    cipher_result_t want;
    gap = draw_idle();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = data;
    in_restart = restart;
    in_end_of_call = end_mark;
    do @(posedge clk); while (!in_ready);
    want.text = data ^ next_keystream_byte(restart);
    want.end_mark = end_mark;
    pending_results.push_back(want);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [chacha_pkg::CFG_IDX_W-1:0] index,
                           input logic [63:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_bytes(input int count, input logic first_restart);
    for (int i = 0; i < count; i++)
      send_byte(8'($urandom_range(0, 255)),
                i == 0 ? first_restart : ($urandom_range(0, 79) == 0),
                $urandom_range(0, 7) == 0);
  endtask

  // The receiver draws a stall for each result, or takes a long hold-off when one is asked for.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = draw_idle();
      if (hold_off_request > 0) begin
        stall = hold_off_request;
        hold_off_request = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    cipher_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result byte %02h end %0b", $time, out_byte, out_end_of_call);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.text) begin
          $display("%0t: out_byte expected %02h, got %02h", $time, want.text, out_byte);
          error_count++;
        end
        if (out_end_of_call !== want.end_mark) begin
          $display("%0t: out_end_of_call expected %0b, got %0b", $time, want.end_mark,
                   out_end_of_call);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count + 1 >= IDLE_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic test_default_config();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b1, 1'b0);
    wait_for_results();
  endtask

  task automatic test_every_register();
    write_reg(chacha_pkg::CFG_KEY_01, {$urandom, $urandom});
    write_reg(chacha_pkg::CFG_KEY_23, {$urandom, $urandom});
    write_reg(chacha_pkg::CFG_KEY_45, {$urandom, $urandom});
    write_reg(chacha_pkg::CFG_KEY_67, {$urandom, $urandom});
    write_reg(chacha_pkg::CFG_CTR_N0, {$urandom, $urandom});
    write_reg(chacha_pkg::CFG_NONCE_12, {$urandom, $urandom});
    write_reg(chacha_pkg::CFG_ROUNDS, {62'd0, chacha_pkg::ROUNDS_8});
    write_reg(chacha_pkg::CFG_KEY_128, 64'd0);
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_round_modes();
    write_reg(chacha_pkg::CFG_ROUNDS, {62'd0, chacha_pkg::ROUNDS_12});
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b0);
    wait_for_results();
    // The reserved mode must behave as twenty rounds; the upper data bits are don't-care.
    write_reg(chacha_pkg::CFG_ROUNDS, {62'h3FFF_FFFF_FFFF_FFFF, ROUNDS_RESERVED});
    send_byte(8'h7F, 1'b1, 1'b1);
    send_byte(8'h10, 1'b0, 1'b0);
    wait_for_results();
    write_reg(chacha_pkg::CFG_ROUNDS, {62'd0, chacha_pkg::ROUNDS_20});
  endtask

  task automatic test_short_key();
    write_reg(chacha_pkg::CFG_KEY_128, 64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'hC3, 1'b1, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1);
    wait_for_results();
    write_reg(chacha_pkg::CFG_KEY_128, 64'd0);
  endtask

  task automatic test_ignored_indexes();
    write_reg(CFG_INDEX_PAST_END, '1);
    write_reg(CFG_INDEX_TOP, '1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    wait_for_results();
  endtask

  task automatic test_extreme_config();
    write_reg(chacha_pkg::CFG_KEY_01, '1);
    write_reg(chacha_pkg::CFG_KEY_23, '1);
    write_reg(chacha_pkg::CFG_KEY_45, '1);
    write_reg(chacha_pkg::CFG_KEY_67, '1);
    write_reg(chacha_pkg::CFG_NONCE_12, '1);
    write_reg(chacha_pkg::CFG_CTR_N0, '1);
    send_byte(8'hAA, 1'b1, 1'b1);
    wait_for_results();
    write_reg(chacha_pkg::CFG_CTR_N0, '0);
    write_reg(chacha_pkg::CFG_KEY_01, '0);
    send_byte(8'h55, 1'b1, 1'b0);
    wait_for_results();
  endtask

  // A key or counter write without a restart must not disturb the block already in use.
  task automatic test_late_register_change();
    send_byte(8'h12, 1'b1, 1'b0);
    wait_for_results();
    write_reg(chacha_pkg::CFG_KEY_01, {$urandom, $urandom});
    write_reg(chacha_pkg::CFG_CTR_N0, {$urandom, $urandom});
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h56, 1'b0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_output_hold_off();
    idle_enabled = 1'b0;
    hold_off_request = HOLD_OFF_CYCLES;
    send_random_bytes(40, 1'b1);
    wait_for_results();
    idle_enabled = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_random_bytes(50, 1'b1);
    wait_for_results();
    send_random_bytes(30, 1'b0);
    wait_for_results();
  endtask

  task automatic test_random_stream();
    int start_count;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1)) write_reg(chacha_pkg::CFG_KEY_01, pick_word64());
      if ($urandom_range(0, 1)) write_reg(chacha_pkg::CFG_KEY_23, pick_word64());
      if ($urandom_range(0, 1)) write_reg(chacha_pkg::CFG_KEY_45, pick_word64());
      if ($urandom_range(0, 1)) write_reg(chacha_pkg::CFG_KEY_67, pick_word64());
      if ($urandom_range(0, 1)) write_reg(chacha_pkg::CFG_NONCE_12, pick_word64());
      case ($urandom_range(0, 3))
        0: write_reg(chacha_pkg::CFG_CTR_N0, {$urandom, 32'hFFFF_FFFF - $urandom_range(0, 2)});
        1: write_reg(chacha_pkg::CFG_CTR_N0, '1);
        default: write_reg(chacha_pkg::CFG_CTR_N0, {$urandom, $urandom});
      endcase
      write_reg(chacha_pkg::CFG_ROUNDS, {$urandom, 30'($urandom), 2'($urandom_range(0, 3))});
      write_reg(chacha_pkg::CFG_KEY_128, {$urandom, $urandom});
      if ($urandom_range(0, 7) == 0)
        write_reg(8'($urandom_range(CFG_INDEX_PAST_END, CFG_INDEX_TOP)), {$urandom, $urandom});
      idle_enabled = ($urandom_range(0, 3) != 0);
      send_random_bytes($urandom_range(20, 160), $urandom_range(0, 3) != 0);
      wait_for_results();
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_config();
    test_every_register();
    test_round_modes();
    test_short_key();
    test_ignored_indexes();
    test_extreme_config();
    test_late_register_change();
    test_output_hold_off();
    test_sender_pause();
    test_random_stream();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: chacha_stream_cipher.f
sv/chacha_pkg.sv
sv/chacha_ctrl.sv
sv/chacha_dp.sv
sv/chacha_stream_cipher.sv
dv/chacha_stream_cipher_test.sv
